// ===== src/cobs_rx_pkg.sv =====
package cobs_rx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 9;
  localparam int unsigned PhaseW = 2;

  localparam logic [PhaseW-1:0] PhIdle  = 2'd0;
  localparam logic [PhaseW-1:0] PhCode  = 2'd1;
  localparam logic [PhaseW-1:0] PhFrame = 2'd2;

  localparam logic [IndexW:0] HeaderBytes = 10'd4;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  frame_byte;
    logic [IndexW-1:0] byte_index;
    logic              frame_end;
    logic              frame_abort;
  } result_t;

endpackage

// ===== src/cobs_frame_receiver.sv =====
// Path: a decoded byte passes the input register, then the result register.
// Throughput: one byte per cycle while out_stall_i is low; the two registers
// decouple the channels, so while a result waits, a byte is still taken into
// the input register as long as that register is empty.
// Reset: asynchronous, active low; clears frame state to idle and empties
// both registers.
module cobs_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cobs_rx_pkg::ByteW-1:0]  rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cobs_rx_pkg::ByteW-1:0]  frame_byte_o,
  output logic [cobs_rx_pkg::IndexW-1:0] byte_index_o,
  output logic                          frame_end_o,
  output logic                          frame_abort_o
);
  import cobs_rx_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic             proceed;
  logic             load;
  result_t          res;

  logic [ByteW-1:0]  frame_byte_q;
  logic [IndexW-1:0] byte_index_q;
  logic              frame_end_q;
  logic              frame_abort_q;

  assign proceed    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proceed;
  assign load       = in_valid_i && !in_stall_o;

  cobs_rx_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proceed),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (proceed) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_byte_q <= rx_byte_i;
    end
    if (res.valid) begin
      frame_byte_q  <= res.frame_byte;
      byte_index_q  <= res.byte_index;
      frame_end_q   <= res.frame_end;
      frame_abort_q <= res.frame_abort;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = frame_byte_q;
  assign byte_index_o  = byte_index_q;
  assign frame_end_o   = frame_end_q;
  assign frame_abort_o = frame_abort_q;

endmodule

// ===== src/cobs_rx_core.sv =====
module cobs_rx_core #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [cobs_rx_pkg::ByteW-1:0] byte_i,
  output cobs_rx_pkg::result_t         res_o
);
  import cobs_rx_pkg::*;

  localparam logic [IndexW:0] AbortAt = (IndexW+1)'(MAX_FRAME_BYTES) + HeaderBytes;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [IndexW-1:0] pos_q, pos_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;

  logic [ByteW-1:0]  cnt_dec;
  logic              hit;
  logic [ByteW-1:0]  dec_byte;
  logic [ByteW-1:0]  len_eff;
  logic [IndexW:0]   next;
  logic              done;
  logic              abort;

  always_comb begin
    cnt_dec  = cnt_q - 8'd1;
    hit      = (cnt_dec == '0);
    dec_byte = hit ? '0 : byte_i;
    len_eff  = (pos_q == '0) ? dec_byte : len_q;
    next     = {1'b0, pos_q} + 10'd1;
    done     = (next >= ({2'b00, len_eff} + HeaderBytes));
    abort    = !done && (next >= AbortAt);

    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    cnt_d   = cnt_q;

    res_o.valid       = 1'b0;
    res_o.frame_byte  = abort ? '0 : dec_byte;
    res_o.byte_index  = pos_q;
    res_o.frame_end   = done;
    res_o.frame_abort = abort;

    if (step_i) begin
      if (byte_i == '0) begin
        phase_d = PhCode;
      end else begin
        unique case (phase_q)
          PhCode: begin
            cnt_d   = byte_i;
            pos_d   = '0;
            phase_d = PhFrame;
          end
          PhFrame: begin
            cnt_d = hit ? byte_i : cnt_dec;
            if (pos_q == '0) begin
              len_d = dec_byte;
            end
            if (done || abort) begin
              phase_d = PhIdle;
              pos_d   = '0;
            end else begin
              pos_d = next[IndexW-1:0];
            end
            res_o.valid = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cobs_rx_pkg::*;

  localparam int MaxFrame   = 128;
  localparam int CycleLimit = 200000;
  localparam int RandomBeats = 330;

  typedef logic [ByteW-1:0] byte_q_t[$];

  typedef struct {
    logic [ByteW-1:0]  frame_byte;
    logic [IndexW-1:0] byte_index;
    logic              frame_end;
    logic              frame_abort;
  } decoded_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ByteW-1:0]  rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ByteW-1:0]  frame_byte_o;
  logic [IndexW-1:0] byte_index_o;
  logic              frame_end_o;
  logic              frame_abort_o;

  cobs_frame_receiver #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .frame_end_o  (frame_end_o),
    .frame_abort_o(frame_abort_o)
  );

  // decoder state mirror
  logic [PhaseW-1:0] dec_phase;
  logic [IndexW-1:0] dec_pos;
  logic [ByteW-1:0]  dec_len;
  logic [ByteW-1:0]  dec_count;

  decoded_beat_t decoded_due[$];
  int            decoded_total;
  int            errors;
  int            checked;
  int            cycle_count;
  int            hold_left;
  bit            tx_idle_on;
  bit            rx_idle_on;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void decode_byte(logic [ByteW-1:0] raw);
    logic [ByteW-1:0]  val;
    logic [IndexW-1:0] idx;
    int                nxt;
    logic              done;
    logic              abrt;
    decoded_beat_t     beat;
    val = raw;
    if (raw == '0) begin
      dec_phase = PhCode;
      return;
    end
    if (dec_phase == PhCode) begin
      dec_count = raw;
      dec_pos   = '0;
      dec_phase = PhFrame;
      return;
    end
    if (dec_phase != PhFrame) return;
    dec_count = dec_count - 8'd1;
    if (dec_count == '0) begin
      dec_count = raw;
      val       = '0;
    end
    idx = dec_pos;
    if (idx == '0) dec_len = val;
    nxt  = int'(idx) + 1;
    done = nxt >= int'(dec_len) + int'(HeaderBytes);
    abrt = !done && (nxt >= MaxFrame + int'(HeaderBytes));
    if (done || abrt) begin
      dec_phase = PhIdle;
      dec_pos   = '0;
    end else begin
      dec_pos = IndexW'(nxt);
    end
    beat.frame_byte  = abrt ? '0 : val;
    beat.byte_index  = idx;
    beat.frame_end   = done;
    beat.frame_abort = abrt;
    decoded_due.push_back(beat);
    decoded_total++;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: expected %0d, got %0d (beat %0d, t=%0t)",
               what, want, got, checked, $time);
  endtask

  always @(posedge clk_i) begin : check_results
    decoded_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_due.size() == 0) begin
        report_mismatch("unexpected beat, byte_index", -1, int'(byte_index_o));
      end else begin
        want = decoded_due.pop_front();
        if (frame_byte_o !== want.frame_byte)
          report_mismatch("frame_byte", want.frame_byte, frame_byte_o);
        if (byte_index_o !== want.byte_index)
          report_mismatch("byte_index", want.byte_index, byte_index_o);
        if (frame_end_o !== want.frame_end)
          report_mismatch("frame_end", want.frame_end, frame_end_o);
        if (frame_abort_o !== want.frame_abort)
          report_mismatch("frame_abort", want.frame_abort, frame_abort_o);
      end
      checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, decoded_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls plus requested hold-offs
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(99) < 16);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk_i);
    while (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] rand_data(int zero_pct);
    if ($urandom_range(99) < zero_pct) return '0;
    return ByteW'($urandom_range(1, 255));
  endfunction

  // stuff each zero with the distance to the next one; the code byte leads
  task automatic send_encoded(input byte_q_t d, input int cut);
    logic [ByteW-1:0] enc[];
    int               n;
    int               nz;
    n   = d.size();
    nz  = n;
    enc = new[n + 1];
    for (int i = n - 1; i >= 0; i--) begin
      if (d[i] == '0) begin
        enc[i + 1] = ByteW'(nz - i);
        nz = i;
      end else begin
        enc[i + 1] = d[i];
      end
    end
    enc[0] = ByteW'(nz + 1);
    send_byte('0);
    for (int i = 0; i <= n; i++) begin
      if (cut >= 0 && i >= cut) break;
      send_byte(enc[i]);
    end
  endtask

  task automatic send_frame(input int len, input int zero_pct, input int cut);
    byte_q_t d;
    int      n;
    n = len + 4;
    if (n > MaxFrame + 7) n = MaxFrame + 7;
    d.push_back(ByteW'(len));
    for (int i = 1; i < n; i++) d.push_back(rand_data(zero_pct));
    send_encoded(d, cut);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 95) return $urandom_range(13, 60);
    return $urandom_range(100, 255);
  endfunction

  task automatic send_noise();
    int cnt;
    cnt = $urandom_range(1, 6);
    repeat (cnt) send_byte(rand_data(30));
  endtask

  task automatic test_directed();
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_encoded('{8'h00, 8'h00, 8'h00, 8'h00}, -1);
    send_encoded('{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, -1);
    // restart mid-frame, then a code byte cut short by a zero
    send_byte(8'h00);
    send_byte(8'h07);
    send_byte(8'h05);
    send_byte(8'h33);
    send_byte(8'h00);
    send_byte(8'h80);
    send_encoded('{8'h02, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h00}, -1);
    send_byte(8'hA5);
    wait_drained();
  endtask

  task automatic test_length_limits();
    send_frame(MaxFrame, 10, -1);
    send_frame(MaxFrame + 1, 10, -1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_left = 80;
    send_frame(20, 10, -1);
    send_frame(12, 20, -1);
    wait_drained();
    hold_left = 150;
    send_frame(30, 5, -1);
    wait_drained();
  endtask

  task automatic test_streaming();
    int stop_at;
    stop_at    = decoded_total + 120;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (decoded_total < stop_at) send_frame(pick_len(), $urandom_range(0, 40), -1);
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int stop_at;
    int r;
    int len;
    stop_at = decoded_total + RandomBeats;
    while (decoded_total < stop_at) begin
      r   = $urandom_range(99);
      len = pick_len();
      if (r < 75) begin
        send_frame(len, $urandom_range(0, 50), -1);
      end else if (r < 85) begin
        send_frame(len, $urandom_range(0, 50), $urandom_range(1, len + 3));
      end else if (r < 95) begin
        send_noise();
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    out_stall_i   = 1'b0;
    dec_phase     = PhIdle;
    dec_pos       = '0;
    dec_len       = '0;
    dec_count     = '0;
    decoded_total = 0;
    errors        = 0;
    checked       = 0;
    cycle_count   = 0;
    hold_left     = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_length_limits();
    test_backpressure();
    test_streaming();
    test_random();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && decoded_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", errors, decoded_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
